@@ src/mqtt_publish_deframer_assert.svh @@
// Assertion macros for the checker file of the deframer.
`ifndef MQTT_PUBLISH_DEFRAMER_ASSERT_SVH
`define MQTT_PUBLISH_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define MPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/mpd_pkg.sv @@
package mpd_pkg;

	// Field widths.
	localparam int LEN_W   = 28;
	localparam int TOPIC_W = 16;
	localparam int TYPE_W  = 4;
	localparam int KIND_W  = 2;

	// Packet type codes.
	localparam logic [TYPE_W-1:0] TYPE_PUBLISH = 4'd3;

	// Byte kind codes on the result channel.
	localparam logic [KIND_W-1:0] KIND_FRAME   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TOPIC   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd2;

	// Queue between the front and back parts.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	// Configuration port: register index is paddr[2].
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;
	localparam logic REG_MAX_REMAINING = 1'b0;
	localparam logic [LEN_W-1:0] MAX_REMAINING_RST = 28'd255;

	// One received byte after classification by the front part.
	typedef struct packed {
		logic [7:0] data;
		logic       abort;
		logic       cont;
	} mpd_item_t;

	// Queue status seen by the front and back parts.
	typedef struct packed {
		logic full;
		logic not_empty;
	} mpd_q_stat_t;

endpackage

@@ src/mpd_intf.sv @@
// Received byte channel.
interface mpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       abort_packet;

	modport source (output valid, output rx_byte, output abort_packet, input ready);
	modport sink (input valid, input rx_byte, input abort_packet, output ready);
endinterface

// Tagged byte channel.
interface mpd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [1:0] byte_kind;
	logic       message_end;
	logic       packet_end;
	logic [3:0] hdr_type;
	logic       oversize_drop;

	modport source (output valid, output data_byte, output byte_kind, output message_end,
		output packet_end, output hdr_type, output oversize_drop, input ready);
	modport sink (input valid, input data_byte, input byte_kind, input message_end,
		input packet_end, input hdr_type, input oversize_drop, output ready);
endinterface

@@ src/mpd_front.sv @@
module mpd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	mpd_in_if.sink               rx,
	input  mpd_pkg::mpd_q_stat_t q_stat,
	output mpd_pkg::mpd_item_t   item_s1,
	output logic                 push
);
	import mpd_pkg::*;

	logic valid_s1;
	logic accept;

	// The stage moves on into the queue whenever the queue has room.
	assign push     = valid_s1 && !q_stat.full;
	assign rx.ready = !valid_s1 || !q_stat.full;
	assign accept   = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Classify the byte: abort flag and the length continuation bit.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data  <= rx.rx_byte;
			item_s1.abort <= rx.abort_packet;
			item_s1.cont  <= rx.rx_byte[7];
		end
	end

endmodule

@@ src/mpd_fifo.sv @@
module mpd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mpd_pkg::mpd_item_t   item_in,
	input  logic                 pop,
	output mpd_pkg::mpd_item_t   item_out,
	output mpd_pkg::mpd_q_stat_t q_stat
);
	import mpd_pkg::*;

	mpd_item_t       mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign q_stat.full      = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign q_stat.not_empty = (count_q != '0);
	assign item_out         = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

@@ src/mpd_back.sv @@
module mpd_back #(
	parameter int TOPIC_CAP = 127
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mpd_pkg::mpd_item_t         item,
	input  mpd_pkg::mpd_q_stat_t       q_stat,
	input  logic [mpd_pkg::LEN_W-1:0]  max_remaining,
	output logic                       pop,
	mpd_out_if.source                  tx
);
	import mpd_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_TLEN_HI,
		PH_TLEN_LO,
		PH_TOPIC,
		PH_PAYLOAD,
		PH_SKIP,
		PH_DRAIN
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [TYPE_W-1:0]  type_q, type_d;
	logic [LEN_W-1:0]   accum_q, accum_d;
	logic [1:0]         lcnt_q, lcnt_d;
	logic [LEN_W-1:0]   left_q, left_d;
	logic [TOPIC_W-1:0] tlen_q, tlen_d;
	logic [TOPIC_W-1:0] tpos_q, tpos_d;

	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic [KIND_W-1:0]  out_kind_q, kind_d;
	logic               out_msg_q, msg_d;
	logic               out_pkt_q, pkt_d;
	logic               out_drop_q, drop_d;

	logic [LEN_W-1:0]   left_dec;
	logic [LEN_W-1:0]   group;
	logic [TOPIC_W-1:0] tlen_full;

	// Take the next byte when the result register is free or being emptied.
	assign pop = q_stat.not_empty && (!out_valid_q || tx.ready);

	assign left_dec  = left_q - 1'b1;
	assign tlen_full = {tlen_q[TOPIC_W-1:8], item.data};

	// Place the 7-bit length group by its position in the field.
	always_comb begin
		unique case (lcnt_q)
			2'd0: group = {21'b0, item.data[6:0]};
			2'd1: group = {14'b0, item.data[6:0], 7'b0};
			2'd2: group = {7'b0, item.data[6:0], 14'b0};
			2'd3: group = {item.data[6:0], 21'b0};
			default: group = '0;
		endcase
	end

	// Parser step for one byte.
	always_comb begin
		phase_d = phase_q;
		type_d  = type_q;
		accum_d = accum_q;
		lcnt_d  = lcnt_q;
		left_d  = left_q;
		tlen_d  = tlen_q;
		tpos_d  = tpos_q;
		kind_d  = KIND_FRAME;
		msg_d   = 1'b0;
		pkt_d   = 1'b0;
		drop_d  = 1'b0;

		if (item.abort) begin
			phase_d = PH_HEADER;
			accum_d = '0;
			lcnt_d  = '0;
			left_d  = '0;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					type_d  = item.data[7:4];
					accum_d = '0;
					lcnt_d  = '0;
					phase_d = PH_LENGTH;
				end
				PH_LENGTH: begin
					accum_d = accum_q | group;
					lcnt_d  = lcnt_q + 1'b1;
					if (!item.cont || lcnt_q == 2'd3) begin
						priority if (accum_d > max_remaining) begin
							left_d  = accum_d;
							phase_d = PH_DRAIN;
						end else if (accum_d == '0) begin
							pkt_d   = 1'b1;
							phase_d = PH_HEADER;
						end else if (type_q == TYPE_PUBLISH && accum_d >= LEN_W'(2)) begin
							left_d  = accum_d;
							phase_d = PH_TLEN_HI;
						end else begin
							left_d  = accum_d;
							phase_d = PH_SKIP;
						end
					end
				end
				PH_TLEN_HI: begin
					tlen_d  = {item.data, 8'b0};
					left_d  = left_dec;
					phase_d = PH_TLEN_LO;
				end
				PH_TLEN_LO: begin
					tlen_d = tlen_full;
					left_d = left_dec;
					tpos_d = '0;
					priority if (LEN_W'(tlen_full) > left_dec) begin
						if (left_dec == '0) begin
							pkt_d   = 1'b1;
							phase_d = PH_HEADER;
						end else begin
							phase_d = PH_SKIP;
						end
					end else if (left_dec == '0) begin
						msg_d   = 1'b1;
						pkt_d   = 1'b1;
						phase_d = PH_HEADER;
					end else begin
						phase_d = (tlen_full != '0) ? PH_TOPIC : PH_PAYLOAD;
					end
				end
				PH_TOPIC: begin
					kind_d = (tpos_q < TOPIC_W'(TOPIC_CAP)) ? KIND_TOPIC : KIND_FRAME;
					tpos_d = tpos_q + 1'b1;
					left_d = left_dec;
					priority if (left_dec == '0) begin
						msg_d   = 1'b1;
						pkt_d   = 1'b1;
						phase_d = PH_HEADER;
					end else if (tpos_d >= tlen_q) begin
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					kind_d = KIND_PAYLOAD;
					left_d = left_dec;
					if (left_dec == '0) begin
						msg_d   = 1'b1;
						pkt_d   = 1'b1;
						phase_d = PH_HEADER;
					end
				end
				PH_SKIP: begin
					left_d = left_dec;
					if (left_dec == '0) begin
						pkt_d   = 1'b1;
						phase_d = PH_HEADER;
					end
				end
				PH_DRAIN: begin
					drop_d = 1'b1;
					left_d = left_dec;
					if (left_dec == '0) begin
						pkt_d   = 1'b1;
						phase_d = PH_HEADER;
					end
				end
				default: phase_d = PH_HEADER;
			endcase
		end
	end

	// Parser state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			type_q      <= '0;
			accum_q     <= '0;
			lcnt_q      <= '0;
			left_q      <= '0;
			tlen_q      <= '0;
			tpos_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				type_q      <= type_d;
				accum_q     <= accum_d;
				lcnt_q      <= lcnt_d;
				left_q      <= left_d;
				tlen_q      <= tlen_d;
				tpos_q      <= tpos_d;
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q <= item.data;
			out_kind_q <= kind_d;
			out_msg_q  <= msg_d;
			out_pkt_q  <= pkt_d;
			out_drop_q <= drop_d;
		end
	end

	assign tx.valid         = out_valid_q;
	assign tx.data_byte     = out_byte_q;
	assign tx.byte_kind     = out_kind_q;
	assign tx.message_end   = out_msg_q;
	assign tx.packet_end    = out_pkt_q;
	assign tx.hdr_type      = type_q;
	assign tx.oversize_drop = out_drop_q;

endmodule

@@ src/mqtt_publish_deframer.sv @@
// Channel  Direction  Carries
// rx       in         rx_byte, abort_packet: one stream byte per transfer
// tx       out        data_byte, byte_kind, message_end, packet_end, hdr_type,
//                     oversize_drop: one tagged byte per received byte
// apb      in         max_remaining at register 0
//
// One byte per cycle is sustained while tx does not stall; the parser state is
// updated once per byte. An rx byte passes through the input stage, the
// four-entry queue and the result register on its way to tx.
// Reset is asynchronous and active low; max_remaining resets to 255.
// A stall on tx fills the queue and then drops rx.ready; the front and back
// stall independently.
module mqtt_publish_deframer #(
	parameter int TOPIC_CAP = 127
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mpd_in_if.sink                      rx,
	mpd_out_if.source                   tx,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mpd_pkg::CFG_AW-1:0]  paddr,
	input  logic [mpd_pkg::CFG_DW-1:0]  pwdata,
	output logic [mpd_pkg::CFG_DW-1:0]  prdata,
	output logic                        pready
);
	import mpd_pkg::*;

	mpd_item_t        item_s1;
	mpd_item_t        q_item;
	mpd_q_stat_t      q_stat;
	logic             push;
	logic             pop;
	logic [LEN_W-1:0] max_remaining_q;
	logic             reg_sel;

	// Configuration register.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_MAX_REMAINING);
	assign prdata  = reg_sel ? CFG_DW'(max_remaining_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_remaining_q <= MAX_REMAINING_RST;
		end else if (psel && penable && pwrite && reg_sel) begin
			max_remaining_q <= pwdata[LEN_W-1:0];
		end
	end

	mpd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.q_stat  (q_stat),
		.item_s1 (item_s1),
		.push    (push)
	);

	mpd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (item_s1),
		.pop      (pop),
		.item_out (q_item),
		.q_stat   (q_stat)
	);

	mpd_back #(
		.TOPIC_CAP (TOPIC_CAP)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (q_item),
		.q_stat        (q_stat),
		.max_remaining (max_remaining_q),
		.pop           (pop),
		.tx            (tx)
	);

endmodule

@@ src/mpd_checker.sv @@
`include "mqtt_publish_deframer_assert.svh"

module mpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [1:0] out_kind,
	input logic       out_msg,
	input logic       out_pkt,
	input logic       out_drop
);
	import mpd_pkg::*;

	// A finished message always closes its packet.
	`MPD_ASSERT_NOW(a_msg_has_pkt, out_valid && out_msg, out_pkt, "message end without packet end")

	// Drained bytes are never tagged and never complete a message.
	`MPD_ASSERT_NOW(a_drop_untagged, out_valid && out_drop, out_kind == KIND_FRAME && !out_msg, "drained byte tagged")

	// Only the three defined byte kinds appear.
	`MPD_ASSERT_NOW(a_kind_legal, out_valid, out_kind == KIND_FRAME || out_kind == KIND_TOPIC || out_kind == KIND_PAYLOAD, "undefined byte kind")

	// A result held by the sink keeps its byte.
	`MPD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_byte), "stalled result changed")

endmodule

bind mqtt_publish_deframer mpd_checker u_mpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (tx.valid),
	.out_ready (tx.ready),
	.out_byte  (tx.data_byte),
	.out_kind  (tx.byte_kind),
	.out_msg   (tx.message_end),
	.out_pkt   (tx.packet_end),
	.out_drop  (tx.oversize_drop)
);

@@ sim/mqtt_publish_deframer_test.sv @@
`timescale 1ns / 1ps

module mqtt_publish_deframer_test;
	import mpd_pkg::*;

	localparam int TOPIC_KEEP = 127;
	localparam logic [CFG_AW-1:0] MAX_REMAINING_ADDR = {REG_MAX_REMAINING, 2'b00};

	// Parser phases of the predictor.
	typedef enum logic [2:0] {
		AWAIT_HEADER, IN_LENGTH, TLEN_HIGH, TLEN_LOW, IN_TOPIC, IN_PAYLOAD, SKIPPING, DRAINING
	} parse_phase_t;

	// One tagged byte as it leaves the block.
	typedef struct packed {
		logic [7:0]        data_byte;
		logic [KIND_W-1:0] byte_kind;
		logic              message_end;
		logic              packet_end;
		logic [TYPE_W-1:0] hdr_type;
		logic              oversize_drop;
	} deframed_t;

	// One byte of the stream, with its abort flag.
	typedef struct packed {
		logic [7:0] value;
		logic       abort;
	} stream_byte_t;

	// A row of the directed stimulus; known rows carry a hand-written tag.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       abort;
		logic       known;
		deframed_t  want;
	} directed_row_t;

	localparam deframed_t NO_TAG = '0;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	mpd_in_if  rx_if ();
	mpd_out_if tx_if ();

	mqtt_publish_deframer #(
		.TOPIC_CAP(TOPIC_KEEP)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_if),
		.tx      (tx_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state and its copy of the length limit.
	parse_phase_t      ph;
	logic [TYPE_W-1:0] pkt_type;
	logic [LEN_W-1:0]  len_acc;
	logic [1:0]        len_bytes;
	logic [LEN_W-1:0]  remain;
	logic [TOPIC_W-1:0] topic_len;
	logic [TOPIC_W-1:0] topic_pos;
	logic [LEN_W-1:0]  limit_len;

	deframed_t    expected_tags [$];
	stream_byte_t outgoing [$];
	int unsigned  mismatch_count;
	int unsigned  send_idle_pct;
	int unsigned  sink_stall_pct;
	logic         byte_has_known;
	deframed_t    byte_known;

	directed_row_t directed_rows [26] = '{
		'{{TYPE_PUBLISH, 4'h0}, 1'b0, 1'b1, '{8'h30, KIND_FRAME, 1'b0, 1'b0, 4'h3, 1'b0}},
		'{8'h00, 1'b0, 1'b1, '{8'h00, KIND_FRAME, 1'b0, 1'b1, 4'h3, 1'b0}},
		'{{TYPE_PUBLISH, 4'hF}, 1'b0, 1'b0, NO_TAG},
		'{8'h01, 1'b0, 1'b0, NO_TAG},
		'{8'hFF, 1'b0, 1'b0, NO_TAG},
		'{{TYPE_PUBLISH, 4'h0}, 1'b0, 1'b0, NO_TAG},
		'{8'h02, 1'b0, 1'b0, NO_TAG},
		'{8'h00, 1'b0, 1'b0, NO_TAG},
		'{8'h00, 1'b0, 1'b0, NO_TAG},
		'{{TYPE_PUBLISH, 4'h0}, 1'b0, 1'b0, NO_TAG},
		'{8'h02, 1'b0, 1'b0, NO_TAG},
		'{8'hFF, 1'b0, 1'b0, NO_TAG},
		'{8'hFF, 1'b0, 1'b0, NO_TAG},
		'{8'hF0, 1'b0, 1'b1, '{8'hF0, KIND_FRAME, 1'b0, 1'b0, 4'hF, 1'b0}},
		'{8'hFF, 1'b0, 1'b1, '{8'hFF, KIND_FRAME, 1'b0, 1'b0, 4'hF, 1'b0}},
		'{8'hFF, 1'b0, 1'b1, '{8'hFF, KIND_FRAME, 1'b0, 1'b0, 4'hF, 1'b0}},
		'{8'hFF, 1'b0, 1'b1, '{8'hFF, KIND_FRAME, 1'b0, 1'b0, 4'hF, 1'b0}},
		'{8'hFF, 1'b0, 1'b1, '{8'hFF, KIND_FRAME, 1'b0, 1'b0, 4'hF, 1'b0}},
		'{8'h00, 1'b0, 1'b1, '{8'h00, KIND_FRAME, 1'b0, 1'b0, 4'hF, 1'b1}},
		'{8'hA5, 1'b1, 1'b1, '{8'hA5, KIND_FRAME, 1'b0, 1'b0, 4'hF, 1'b0}},
		'{{TYPE_PUBLISH, 4'h0}, 1'b0, 1'b0, NO_TAG},
		'{8'h04, 1'b0, 1'b0, NO_TAG},
		'{8'h00, 1'b0, 1'b0, NO_TAG},
		'{8'h01, 1'b0, 1'b0, NO_TAG},
		'{8'h61, 1'b0, 1'b0, NO_TAG},
		'{8'h62, 1'b0, 1'b0, NO_TAG}
	};

	// Idling, stalling, length limit and byte quota of each random phase.
	int unsigned      phase_idle [4]  = '{0, 62, 0, 27};
	int unsigned      phase_stall [4] = '{0, 0, 62, 27};
	logic [LEN_W-1:0] phase_limit [4] = '{28'd160, 28'd0, 28'h0FFFFFFF, 28'd24};
	int unsigned      phase_quota [4] = '{170, 160, 160, 160};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Tags one received byte and advances the parser state.
	function automatic deframed_t deframe(input logic [7:0] b, input logic ab);
		deframed_t r;
		logic last;
		r = '0;
		r.data_byte = b;
		if (ab) begin
			ph = AWAIT_HEADER;
			len_acc = '0;
			len_bytes = '0;
			remain = '0;
		end else begin
			case (ph)
				AWAIT_HEADER: begin
					pkt_type = b[7:4];
					len_acc = '0;
					len_bytes = '0;
					ph = IN_LENGTH;
				end
				IN_LENGTH: begin
					last = !b[7] || len_bytes == 2'd3;
					len_acc = len_acc | (LEN_W'(b[6:0]) << (7 * len_bytes));
					len_bytes = len_bytes + 2'd1;
					if (last) begin
						remain = len_acc;
						if (len_acc > limit_len) begin
							ph = DRAINING;
						end else if (len_acc == 0) begin
							r.packet_end = 1'b1;
							ph = AWAIT_HEADER;
						end else if (pkt_type == TYPE_PUBLISH && len_acc >= 2) begin
							ph = TLEN_HIGH;
						end else begin
							ph = SKIPPING;
						end
					end
				end
				TLEN_HIGH: begin
					topic_len = {b, 8'h00};
					remain = remain - 1'b1;
					ph = TLEN_LOW;
				end
				TLEN_LOW: begin
					topic_len = {topic_len[15:8], b};
					remain = remain - 1'b1;
					topic_pos = '0;
					if (LEN_W'(topic_len) > remain) begin
						// The topic cannot fit: skip whatever is left.
						if (remain == 0) begin
							r.packet_end = 1'b1;
							ph = AWAIT_HEADER;
						end else begin
							ph = SKIPPING;
						end
					end else if (remain == 0) begin
						r.message_end = 1'b1;
						r.packet_end = 1'b1;
						ph = AWAIT_HEADER;
					end else begin
						ph = (topic_len != 0) ? IN_TOPIC : IN_PAYLOAD;
					end
				end
				IN_TOPIC: begin
					r.byte_kind = (topic_pos < TOPIC_KEEP) ? KIND_TOPIC : KIND_FRAME;
					topic_pos = topic_pos + 1'b1;
					remain = remain - 1'b1;
					if (remain == 0) begin
						r.message_end = 1'b1;
						r.packet_end = 1'b1;
						ph = AWAIT_HEADER;
					end else if (topic_pos >= topic_len) begin
						ph = IN_PAYLOAD;
					end
				end
				IN_PAYLOAD: begin
					r.byte_kind = KIND_PAYLOAD;
					remain = remain - 1'b1;
					if (remain == 0) begin
						r.message_end = 1'b1;
						r.packet_end = 1'b1;
						ph = AWAIT_HEADER;
					end
				end
				SKIPPING: begin
					remain = remain - 1'b1;
					if (remain == 0) begin
						r.packet_end = 1'b1;
						ph = AWAIT_HEADER;
					end
				end
				default: begin
					r.oversize_drop = 1'b1;
					remain = remain - 1'b1;
					if (remain == 0) begin
						r.packet_end = 1'b1;
						ph = AWAIT_HEADER;
					end
				end
			endcase
		end
		r.hdr_type = pkt_type;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] seen);
		if (seen !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, what, want, seen);
			mismatch_count++;
		end
	endtask

	// Offers one byte, after a random gap, and holds it until the transfer.
	task automatic send_byte(input logic [7:0] b, input logic ab, input logic has_known,
			input deframed_t known_tag);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		rx_if.abort_packet <= ab;
		byte_has_known <= has_known;
		byte_known <= known_tag;
		do @(posedge clk); while (!rx_if.ready);
	endtask

	// Stops sending and waits until every expected tag has come back.
	task automatic wait_quiet();
		rx_if.valid <= 1'b0;
		do @(posedge clk); while (expected_tags.size() != 0);
	endtask

	// Writes the length limit over the configuration port and reads it back.
	task automatic write_max_remaining(input logic [LEN_W-1:0] value);
		wait_quiet();
		repeat (8) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MAX_REMAINING_ADDR;
		pwdata <= CFG_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		limit_len = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("max_remaining readback", 32'(value), 32'(prdata[LEN_W-1:0]));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Appends one packet, mostly well formed, sometimes noise or cut short.
	task automatic queue_packet();
		stream_byte_t pkt [$];
		int unsigned pick, tl, pl, nb, n;
		logic [TYPE_W-1:0] ptype;
		logic [LEN_W-1:0] len;
		logic [TOPIC_W-1:0] declared;
		pick = $urandom_range(99);
		if (pick < 6) begin
			// Line noise, then an abort to resynchronise.
			n = $urandom_range(1, 6);
			repeat (n) pkt.push_back('{8'($urandom), 1'b0});
			pkt.push_back('{8'($urandom), 1'b1});
		end else if (pick < 10) begin
			// Four length bytes all with continuation set, cut off by an abort.
			pkt.push_back('{8'($urandom), 1'b0});
			repeat (4) pkt.push_back('{8'h80 | 8'($urandom), 1'b0});
			n = $urandom_range(0, 4);
			repeat (n) pkt.push_back('{8'($urandom), 1'b0});
			pkt.push_back('{8'($urandom), 1'b1});
		end else begin
			ptype = (pick < 75) ? TYPE_PUBLISH : 4'($urandom);
			tl = ($urandom_range(19) == 0) ? $urandom_range(120, 140) : $urandom_range(0, 12);
			pl = $urandom_range(0, 20);
			if (ptype == TYPE_PUBLISH)
				len = ($urandom_range(15) == 0) ? LEN_W'($urandom_range(0, 1)) : LEN_W'(2 + tl + pl);
			else
				len = LEN_W'($urandom_range(0, 30));
			declared = ($urandom_range(11) == 0) ? TOPIC_W'($urandom_range(tl + pl + 1, 65535))
				: TOPIC_W'(tl);
			pkt.push_back('{{ptype, 4'($urandom)}, 1'b0});
			// Minimal length encoding, sometimes padded with extra groups.
			nb = 1;
			while (nb < 4 && (len >> (7 * nb)) != 0)
				nb++;
			if ($urandom_range(7) == 0)
				nb = $urandom_range(nb, 4);
			for (int i = 0; i < nb; i++)
				pkt.push_back('{{(i < nb - 1) ? 1'b1 : 1'b0, len[7*i +: 7]}, 1'b0});
			if (ptype == TYPE_PUBLISH && len >= 2) begin
				pkt.push_back('{declared[15:8], 1'b0});
				pkt.push_back('{declared[7:0], 1'b0});
				repeat (len - 2) pkt.push_back('{8'($urandom), 1'b0});
			end else begin
				repeat (len) pkt.push_back('{8'($urandom), 1'b0});
			end
			// Now and then the packet is cut short and the link aborts.
			if ($urandom_range(19) == 0 && pkt.size() > 2) begin
				n = $urandom_range(1, pkt.size() - 1);
				repeat (n) pkt.delete(pkt.size() - 1);
				pkt.push_back('{8'($urandom), 1'b1});
			end
		end
		foreach (pkt[i])
			outgoing.push_back(pkt[i]);
	endtask

	// The receiver stalls at random.
	always @(posedge clk)
		tx_if.ready <= ($urandom_range(99) >= sink_stall_pct);

	// Predict on each input transfer, check on each output transfer.
	always @(posedge clk) begin
		deframed_t want;
		deframed_t seen;
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready) begin
				want = deframe(rx_if.rx_byte, rx_if.abort_packet);
				if (byte_has_known)
					want = byte_known;
				expected_tags.push_back(want);
			end
			if (tx_if.valid && tx_if.ready) begin
				seen = '{tx_if.data_byte, tx_if.byte_kind, tx_if.message_end, tx_if.packet_end,
					tx_if.hdr_type, tx_if.oversize_drop};
				if (expected_tags.size() == 0) begin
					$display("%0t: tagged byte %0h arrived with nothing expected", $time, seen);
					mismatch_count++;
				end else begin
					want = expected_tags.pop_front();
					check_field("data_byte", 32'(want.data_byte), 32'(seen.data_byte));
					check_field("byte_kind", 32'(want.byte_kind), 32'(seen.byte_kind));
					check_field("message_end", 32'(want.message_end), 32'(seen.message_end));
					check_field("packet_end", 32'(want.packet_end), 32'(seen.packet_end));
					check_field("hdr_type", 32'(want.hdr_type), 32'(seen.hdr_type));
					check_field("oversize_drop", 32'(want.oversize_drop),
						32'(seen.oversize_drop));
				end
			end
		end
	end

	// Main sequence: reset, directed rows, then the random phases.
	initial begin
		int unsigned sent;
		stream_byte_t sb;
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		rx_if.abort_packet = 1'b0;
		tx_if.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_has_known = 1'b0;
		byte_known = NO_TAG;
		mismatch_count = 0;
		send_idle_pct = 0;
		sink_stall_pct = 0;
		ph = AWAIT_HEADER;
		pkt_type = '0;
		len_acc = '0;
		len_bytes = '0;
		remain = '0;
		topic_len = '0;
		topic_pos = '0;
		limit_len = MAX_REMAINING_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx_byte, directed_rows[i].abort,
				directed_rows[i].known, directed_rows[i].want);

		for (int p = 0; p < 4; p++) begin
			write_max_remaining(phase_limit[p]);
			send_idle_pct = phase_idle[p];
			sink_stall_pct = phase_stall[p];
			sent = 0;
			while (sent < phase_quota[p] || outgoing.size() != 0) begin
				if (outgoing.size() == 0) begin
					// Occasionally let the block run dry before the next packet.
					if ($urandom_range(24) == 0 || sent == 0)
						wait_quiet();
					queue_packet();
				end
				sb = outgoing.pop_front();
				send_byte(sb.value, sb.abort, 1'b0, NO_TAG);
				if (!sb.abort)
					sent++;
			end
		end

		wait_quiet();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#3000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/mpd_pkg.sv
src/mpd_intf.sv
src/mpd_front.sv
src/mpd_fifo.sv
src/mpd_back.sv
src/mqtt_publish_deframer.sv
src/mpd_checker.sv
sim/mqtt_publish_deframer_test.sv
